FILE: hdl/ultrasonic_echo_ranger_assert.svh
// Assertion macros shared by the ranger modules.
// Every check samples on the rising clock edge.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// This check is switched off while reset is high.
`define UER_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// This check also holds during reset.
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/uer_pkg.sv
`default_nettype none
package uer_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_HOLDOFF      = 3'd0;
   localparam logic [2:0] REG_TRIGGER      = 3'd1;
   localparam logic [2:0] REG_MIN_ECHO     = 3'd2;
   localparam logic [2:0] REG_MAX_ECHO     = 3'd3;
   localparam logic [2:0] REG_OFFSET       = 3'd4;
   localparam logic [2:0] REG_SCALE        = 3'd5;
   localparam logic [2:0] REG_MAX_DISTANCE = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Values after reset.
   localparam logic [19:0] HOLDOFF_RESET      = 20'd60000;
   localparam logic [7:0]  TRIGGER_RESET      = 8'd12;
   localparam logic [19:0] MIN_ECHO_RESET     = 20'd150;
   localparam logic [19:0] MAX_ECHO_RESET     = 20'd25000;
   localparam logic [23:0] OFFSET_RESET       = 24'd320340;
   localparam logic [15:0] SCALE_RESET        = 16'd1778;
   localparam logic [19:0] MAX_DISTANCE_RESET = 20'd102400;

   // Status word codes.
   localparam logic [3:0] ST_IDLE   = 4'h0;
   localparam logic [3:0] ST_PINGED = 4'h1;
   localparam logic [3:0] ST_HIGH   = 4'h2;
   localparam logic [3:0] ST_GOT    = 4'h4;
   localparam logic [3:0] ST_FAULT  = 4'h8;

   typedef struct packed {
      logic [19:0] holdoff_ticks;
      logic [7:0]  trigger_ticks;
      logic [19:0] min_echo_ticks;
      logic [19:0] max_echo_ticks;
      logic [23:0] offset_q8;
      logic [15:0] scale_q16;
      logic [19:0] max_distance_q8;
   } cfg_type;

   typedef struct packed {
      logic        trigger_level;
      logic        distance_valid;
      logic [19:0] distance_q8;
      logic        ping_started;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/uer_csr.sv
`default_nettype none
module uer_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output uer_pkg::cfg_type                     cfg
);
   import uer_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Data wider than a register is cut to that register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_HOLDOFF:      cfg_in.holdoff_ticks   = csr_write_data[19:0];
            REG_TRIGGER:      cfg_in.trigger_ticks   = csr_write_data[7:0];
            REG_MIN_ECHO:     cfg_in.min_echo_ticks  = csr_write_data[19:0];
            REG_MAX_ECHO:     cfg_in.max_echo_ticks  = csr_write_data[19:0];
            REG_OFFSET:       cfg_in.offset_q8       = csr_write_data[23:0];
            REG_SCALE:        cfg_in.scale_q16       = csr_write_data[15:0];
            REG_MAX_DISTANCE: cfg_in.max_distance_q8 = csr_write_data[19:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holdoff_ticks   <= HOLDOFF_RESET;
         cfg_ff.trigger_ticks   <= TRIGGER_RESET;
         cfg_ff.min_echo_ticks  <= MIN_ECHO_RESET;
         cfg_ff.max_echo_ticks  <= MAX_ECHO_RESET;
         cfg_ff.offset_q8       <= OFFSET_RESET;
         cfg_ff.scale_q16       <= SCALE_RESET;
         cfg_ff.max_distance_q8 <= MAX_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: hdl/uer_dist.sv
`default_nettype none
module uer_dist (
   input  wire logic [31:0]      width,
   input  wire uer_pkg::cfg_type cfg,
   output logic                  dist_ok,
   output logic [19:0]           dist_q8
);
   import uer_pkg::*;

   logic        in_range;
   logic [28:0] diff;
   logic        diff_neg;
   logic [43:0] prod;
   logic [27:0] dist_full;
   logic        scale_zero;

   assign in_range = (width >= {12'd0, cfg.min_echo_ticks})
                  && (width <= {12'd0, cfg.max_echo_ticks});

   // Inside the bounds the width fits 20 bits, so the difference fits 29 bits signed.
   assign diff     = {1'b0, width[19:0], 8'h00} - {5'd0, cfg.offset_q8};
   assign diff_neg = diff[28];

   assign prod       = diff[27:0] * cfg.scale_q16;
   assign dist_full  = prod[43:16];
   assign scale_zero = (cfg.scale_q16 == 16'd0);

   // A negative difference gives a negative product unless the scale is zero.
   always_comb begin
      dist_ok = 1'b0;
      dist_q8 = 20'd0;
      if (in_range) begin
         if (diff_neg) begin
            dist_ok = scale_zero;
         end else if (dist_full <= {8'd0, cfg.max_distance_q8}) begin
            dist_ok = 1'b1;
            dist_q8 = dist_full[19:0];
         end
      end
   end

endmodule
`default_nettype wire

FILE: hdl/uer_core.sv
`default_nettype none
`include "ultrasonic_echo_ranger_assert.svh"
module uer_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             echo_level,
   input  wire logic             read_request,
   input  wire uer_pkg::cfg_type cfg,
   output uer_pkg::result_type   result
);
   import uer_pkg::*;

   logic [31:0] tick_ff, tick_in;
   logic [3:0]  status_ff, status_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] end_ff, end_in;
   logic [31:0] last_ff, last_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic        echo_prev_ff, echo_prev_in;

   logic [3:0]  status_e;
   logic [31:0] start_e;
   logic [31:0] end_e;
   logic [31:0] width;
   logic        dist_ok;
   logic [19:0] dist_q8;

   // Echo edges first.
   always_comb begin
      status_e = status_ff;
      start_e  = start_ff;
      end_e    = end_ff;
      if (echo_level != echo_prev_ff) begin
         if (echo_level) begin
            if ((status_ff & ST_PINGED) != ST_IDLE) begin
               start_e  = tick_ff;
               status_e = status_ff | ST_HIGH;
            end else begin
               status_e = ST_FAULT;
            end
         end else begin
            if ((status_ff & ST_HIGH) != ST_IDLE) begin
               end_e    = tick_ff;
               status_e = status_ff | ST_GOT;
            end else begin
               status_e = ST_FAULT;
            end
         end
      end
   end

   assign width = end_e - start_e;

   uer_dist u_dist (
      .width   (width),
      .cfg     (cfg),
      .dist_ok (dist_ok),
      .dist_q8 (dist_q8)
   );

   // Then the read request, then the trigger countdown and the tick.
   always_comb begin
      logic [3:0]  st;
      logic [7:0]  cd;
      st           = status_e;
      start_in     = start_e;
      end_in       = end_e;
      last_in      = last_ff;
      cd           = countdown_ff;
      result       = '0;
      if (read_request) begin
         if (st == ST_FAULT) begin
            last_in = tick_ff;
            st      = ST_IDLE;
         end
         if ((st & ST_GOT) != ST_IDLE) begin
            st                    = ST_IDLE;
            last_in               = tick_ff;
            result.distance_valid = dist_ok;
            result.distance_q8    = dist_q8;
         end
         if (st == ST_IDLE) begin
            if ((tick_ff - last_in) >= {12'd0, cfg.holdoff_ticks}) begin
               last_in             = tick_ff;
               start_in            = 32'd0;
               end_in              = 32'd0;
               st                  = ST_PINGED;
               cd                  = cfg.trigger_ticks;
               result.ping_started = 1'b1;
            end
         end else begin
            last_in = tick_ff;
         end
      end
      result.trigger_level = (cd != 8'd0);
      countdown_in = (cd != 8'd0) ? cd - 8'd1 : cd;
      status_in    = st;
      echo_prev_in = echo_level;
      tick_in      = tick_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= 32'd0;
         status_ff    <= ST_IDLE;
         start_ff     <= 32'd0;
         end_ff       <= 32'd0;
         last_ff      <= 32'd0;
         countdown_ff <= 8'd0;
         echo_prev_ff <= 1'b0;
      end else if (step) begin
         tick_ff      <= tick_in;
         status_ff    <= status_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         last_ff      <= last_in;
         countdown_ff <= countdown_in;
         echo_prev_ff <= echo_prev_in;
      end
   end

   `UER_ASSERT(a_fault_alone, status_ff[3] |-> (status_ff == ST_FAULT), "fault not alone")
   `UER_ASSERT(a_got_after_high, status_ff[2] |-> (&status_ff[1:0]), "echo received early")
   `UER_ASSERT(a_high_after_ping, status_ff[1] |-> status_ff[0], "echo high without a ping")

endmodule
`default_nettype wire

FILE: hdl/ultrasonic_echo_ranger.sv
// A request transfer is held in the input register, then its result in the response register.
// Throughput: one request per cycle; the input register frees when the response register is free.
// Each tick is handled in the single cycle it moves from the input register to the response register.
// Reset is synchronous and active high: the counters, status and trigger return to idle,
// and the configuration registers return to their documented defaults.
`default_nettype none
`include "ultrasonic_echo_ranger_assert.svh"
module ultrasonic_echo_ranger (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_echo_level,
   input  wire logic                            req_read_request,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_trigger_level,
   output logic                                 rsp_distance_valid,
   output logic [19:0]                          rsp_distance_q8,
   output logic                                 rsp_ping_started,
   input  wire logic                            csr_write_enable,
   input  wire logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import uer_pkg::*;

   // The input register holds one tick sample until the response register can take
   // its result; the response register holds that result until its transfer.
   logic       in_valid_ff, in_valid_in;
   logic       in_echo_ff;
   logic       in_read_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       req_take;
   logic       out_free;
   logic       step;
   cfg_type    cfg;
   result_type result;

   uer_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The response register is free when empty or when its transfer completes now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   // A held tick is processed, and the ranging state advances, only when it can be passed on.
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   uer_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .echo_level   (in_echo_ff),
      .read_request (in_read_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_echo_ff <= req_echo_level;
         in_read_ff <= req_read_request;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_trigger_level  = out_ff.trigger_level;
   assign rsp_distance_valid = out_ff.distance_valid;
   assign rsp_distance_q8    = out_ff.distance_q8;
   assign rsp_ping_started   = out_ff.ping_started;

   // The input side only holds off while a tick sits waiting behind a stalled response.
   `UER_ASSERT_ALWAYS(a_stall_needs_item, req_stall |-> in_valid_ff, "stall with empty input register")
   // A tick is never processed while the response register still holds an untaken result.
   `UER_ASSERT(a_no_overwrite, (out_valid_ff && rsp_stall) |-> !step, "response overwritten")
   // A distance is only reported together with the valid flag.
   `UER_ASSERT(a_distance_zero, (out_valid_ff && !out_ff.distance_valid) |-> (out_ff.distance_q8 == 20'd0), "distance without valid flag")

endmodule
`default_nettype wire
